@@ design/spld_pkg.sv @@
// ----------------------------------------------------------------------------
// spld_pkg: shared types and constants for the sorted pair list diff
// Item layouts, action and class codes, and controller/datapath interface.
// ----------------------------------------------------------------------------
package spld_pkg;

  localparam int PREV_DEPTH = 32;
  localparam int PTR_W      = $clog2(PREV_DEPTH + 1);
  localparam int ADDR_W     = (PREV_DEPTH > 1) ? $clog2(PREV_DEPTH) : 1;

  typedef enum logic [1:0] {
    ACT_LOAD = 2'd0,
    ACT_CUR  = 2'd1,
    ACT_FIN  = 2'd2
  } act_t;

  typedef enum logic [1:0] {
    CLS_NEW     = 2'd0,
    CLS_KEPT    = 2'd1,
    CLS_REMOVED = 2'd2,
    CLS_DONE    = 2'd3
  } cls_t;

  // input pair, pair_key in the lowest bits
  typedef struct packed {
    logic [31:0] contact_ref;
    logic        pair_active;
    logic [7:0]  motion_b;
    logic [7:0]  motion_a;
    logic [15:0] object_b;
    logic [15:0] object_a;
    logic [31:0] pair_key;
  } item_t;

  // result payload, out_key in the lowest bits
  typedef struct packed {
    logic [5:0]  count_removed;
    logic [5:0]  count_kept;
    logic [15:0] count_new;
    logic [31:0] out_contact;
    logic        out_active;
    logic [7:0]  out_motion_b;
    logic [7:0]  out_motion_a;
    logic [15:0] out_object_b;
    logic [15:0] out_object_a;
    logic [31:0] out_key;
  } res_t;

  localparam int ITEM_W   = $bits(item_t);
  localparam int RES_W    = $bits(res_t);
  localparam int S_DATA_W = ((ITEM_W + 7) / 8) * 8;
  localparam int M_DATA_W = ((RES_W + 7) / 8) * 8;

  typedef struct packed {
    logic load;          // write incoming pair into the store
    logic capture;       // latch incoming current/finish item
    logic emit_removed;
    logic emit_kept;
    logic emit_new;
    logic emit_done;
  } dp_cmd_t;

  typedef struct packed {
    act_t act;           // action of the captured item
    logic avail;         // stored pair left at read pointer
    logic key_lt;        // stored key below captured key
    logic key_eq;
    logic out_free;      // output register can take a result
  } dp_sts_t;

endpackage

@@ design/spld_ram.sv @@
// ----------------------------------------------------------------------------
// spld_ram: generic simple dual-port RAM
// One write port, one read port with registered read data.
// ----------------------------------------------------------------------------
module spld_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 32
) (
  input  logic                                      clk,
  input  logic                                      we,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  logic [WIDTH-1:0]                          wdata,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic [WIDTH-1:0]                          rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

@@ design/spld_dp.sv @@
// ----------------------------------------------------------------------------
// spld_dp: datapath of the sorted pair list diff
// Pair store, fill and read pointers, counters, compare and output register.
// ----------------------------------------------------------------------------
module spld_dp
  import spld_pkg::*;
(
  input  logic    clk,
  input  logic    rst,
  input  dp_cmd_t cmd,
  output dp_sts_t sts,
  input  item_t   in_item,
  input  act_t    in_act,
  output logic    out_valid,
  input  logic    out_ready,
  output res_t    out_res,
  output cls_t    out_cls,
  output logic    out_last
);

  logic [PTR_W-1:0] fill;
  logic [PTR_W-1:0] read_ptr;
  logic [15:0]      new_count;
  logic [5:0]       kept_count;
  logic [5:0]       removed_count;
  item_t            cur;
  act_t             cur_act;
  item_t            rd_item;
  logic             load_ok;
  logic             emit;
  res_t             res_next;
  cls_t             cls_next;
  logic             last_next;

  assign load_ok = cmd.load && (fill < PTR_W'(PREV_DEPTH));
  assign emit    = cmd.emit_removed | cmd.emit_kept | cmd.emit_new | cmd.emit_done;

  spld_ram #(
    .WIDTH (ITEM_W),
    .DEPTH (PREV_DEPTH)
  ) u_store (
    .clk   (clk),
    .we    (load_ok),
    .waddr (fill[ADDR_W-1:0]),
    .wdata (in_item),
    .raddr (read_ptr[ADDR_W-1:0]),
    .rdata (rd_item)
  );

  // read data for read_ptr is valid in the cycle after the pointer settles
  assign sts.act      = cur_act;
  assign sts.avail    = read_ptr < fill;
  assign sts.key_lt   = rd_item.pair_key < cur.pair_key;
  assign sts.key_eq   = rd_item.pair_key == cur.pair_key;
  assign sts.out_free = !out_valid || out_ready;

  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      cur     <= in_item;
      cur_act <= in_act;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      fill          <= '0;
      read_ptr      <= '0;
      new_count     <= '0;
      kept_count    <= '0;
      removed_count <= '0;
    end else begin
      if (load_ok) begin
        fill <= fill + PTR_W'(1);
      end
      if (cmd.emit_removed) begin
        read_ptr      <= read_ptr + PTR_W'(1);
        removed_count <= removed_count + 6'd1;
      end
      if (cmd.emit_kept) begin
        read_ptr   <= read_ptr + PTR_W'(1);
        kept_count <= kept_count + 6'd1;
      end
      if (cmd.emit_new && (new_count != 16'hFFFF)) begin
        new_count <= new_count + 16'd1;
      end
      if (cmd.emit_done) begin
        fill          <= '0;
        read_ptr      <= '0;
        new_count     <= '0;
        kept_count    <= '0;
        removed_count <= '0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (emit) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_comb begin
    res_next  = '0;
    cls_next  = CLS_NEW;
    last_next = 1'b1;
    if (cmd.emit_removed) begin
      cls_next              = CLS_REMOVED;
      last_next             = 1'b0;
      res_next.out_key      = rd_item.pair_key;
      res_next.out_object_a = rd_item.object_a;
      res_next.out_object_b = rd_item.object_b;
      res_next.out_motion_a = rd_item.motion_a;
      res_next.out_motion_b = rd_item.motion_b;
      res_next.out_active   = rd_item.pair_active;
      res_next.out_contact  = rd_item.contact_ref;
    end else if (cmd.emit_done) begin
      cls_next               = CLS_DONE;
      res_next.count_new     = new_count;
      res_next.count_kept    = kept_count;
      res_next.count_removed = removed_count;
    end else begin
      cls_next              = cmd.emit_kept ? CLS_KEPT : CLS_NEW;
      res_next.out_key      = cur.pair_key;
      res_next.out_object_a = cur.object_a;
      res_next.out_object_b = cur.object_b;
      res_next.out_motion_a = cur.motion_a;
      res_next.out_motion_b = cur.motion_b;
      res_next.out_active   = cur.pair_active;
      res_next.out_contact  = cmd.emit_kept ? rd_item.contact_ref : cur.contact_ref;
    end
  end

  always_ff @(posedge clk) begin
    if (emit) begin
      out_res  <= res_next;
      out_cls  <= cls_next;
      out_last <= last_next;
    end
  end

`ifndef SYNTHESIS
  a_ptr_le_fill: assert property (@(posedge clk) disable iff (rst)
    read_ptr <= fill)
    else $error("read pointer passed fill count");

  a_fill_bound: assert property (@(posedge clk) disable iff (rst)
    fill <= PTR_W'(PREV_DEPTH))
    else $error("fill count beyond store depth");

  a_done_clears: assert property (@(posedge clk) disable iff (rst)
    cmd.emit_done |=> (fill == '0) && (read_ptr == '0) && (kept_count == '0))
    else $error("done result did not clear the store");

  a_emit_free: assert property (@(posedge clk) disable iff (rst)
    emit |-> (!out_valid || out_ready))
    else $error("result emitted over a pending result");
`endif

endmodule

@@ design/spld_ctrl.sv @@
// ----------------------------------------------------------------------------
// spld_ctrl: controller of the sorted pair list diff
// Accepts items, sequences store reads and the merge compare per result.
// ----------------------------------------------------------------------------
module spld_ctrl
  import spld_pkg::*;
(
  input  logic       clk,
  input  logic       rst,
  input  logic       in_valid,
  input  logic [1:0] in_action,
  output logic       in_ready,
  output dp_cmd_t    cmd,
  input  dp_sts_t    sts
);

  typedef enum logic [2:0] {
    S_IDLE = 3'b001,
    S_READ = 3'b010,
    S_CMP  = 3'b100
  } state_t;

  state_t state;
  state_t state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    cmd        = '0;
    in_ready   = 1'b0;
    unique case (state)
      S_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          unique case (in_action)
            ACT_LOAD: cmd.load = 1'b1;
            ACT_CUR, ACT_FIN: begin
              cmd.capture = 1'b1;
              state_next  = S_READ;
            end
            default: ;  // unused action code, dropped
          endcase
        end
      end
      // store read data for the read pointer lands at the end of this cycle
      S_READ: state_next = S_CMP;
      S_CMP: begin
        if (sts.out_free) begin
          if (sts.act == ACT_FIN) begin
            if (sts.avail) begin
              cmd.emit_removed = 1'b1;
              state_next       = S_READ;
            end else begin
              cmd.emit_done = 1'b1;
              state_next    = S_IDLE;
            end
          end else begin
            priority if (sts.avail && sts.key_lt) begin
              cmd.emit_removed = 1'b1;
              state_next       = S_READ;
            end else if (sts.avail && sts.key_eq) begin
              cmd.emit_kept = 1'b1;
              state_next    = S_IDLE;
            end else begin
              cmd.emit_new = 1'b1;
              state_next   = S_IDLE;
            end
          end
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

endmodule

@@ design/sorted_pair_list_diff.sv @@
// ----------------------------------------------------------------------------
// sorted_pair_list_diff: merge diff of two key-sorted pair lists
// Classifies current pairs against stored previous pairs as new/kept/removed.
// ----------------------------------------------------------------------------
// Usage:
//   Input stream s_axis_*: tuser carries the action (load previous pair,
//   current pair, finish), tdata the pair. Load all previous pairs first
//   (up to PREV_DEPTH, extra loads are dropped), then stream current pairs in
//   ascending key order, then one finish item.
//   Output stream m_axis_*: tuser is the class (new, kept, removed, done),
//   tlast marks the final result caused by one input item. The done result
//   carries the three counts and clears the store for the next frame.
// Sequence:
//   A load gives no result. A current pair is accepted in the idle state,
//   then each result takes a registered store read state and a key compare
//   state; stored pairs with lower keys are drained as removed before its
//   kept or new result. A finish drains the remaining pairs as removed,
//   then gives the done result. The next item is taken only back in idle.
// Reset: store becomes empty, counters zero, no result pending.
// Stall: results wait in a one-deep output register; the compare holds
//   while that register is occupied and not taken.
// ----------------------------------------------------------------------------
module sorted_pair_list_diff
  import spld_pkg::*;
(
  input  logic                clk,
  input  logic                rst,
  input  logic                s_axis_tvalid,
  output logic                s_axis_tready,
  // pair_key, object_a, object_b, motion_a, motion_b, pair_active, contact_ref
  input  logic [S_DATA_W-1:0] s_axis_tdata,
  // action
  input  logic [1:0]          s_axis_tuser,
  output logic                m_axis_tvalid,
  input  logic                m_axis_tready,
  // out_key, out_object_a, out_object_b, out_motion_a, out_motion_b,
  // out_active, out_contact, count_new, count_kept, count_removed
  output logic [M_DATA_W-1:0] m_axis_tdata,
  // pair_class
  output logic [1:0]          m_axis_tuser,
  output logic                m_axis_tlast
);

  dp_cmd_t cmd;
  dp_sts_t sts;
  res_t    res;
  cls_t    cls;

  spld_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (s_axis_tvalid),
    .in_action (s_axis_tuser),
    .in_ready  (s_axis_tready),
    .cmd       (cmd),
    .sts       (sts)
  );

  spld_dp u_dp (
    .clk       (clk),
    .rst       (rst),
    .cmd       (cmd),
    .sts       (sts),
    .in_item   (item_t'(s_axis_tdata[ITEM_W-1:0])),
    .in_act    (act_t'(s_axis_tuser)),
    .out_valid (m_axis_tvalid),
    .out_ready (m_axis_tready),
    .out_res   (res),
    .out_cls   (cls),
    .out_last  (m_axis_tlast)
  );

  assign m_axis_tdata = M_DATA_W'(res);
  assign m_axis_tuser = cls;

endmodule
